FILE: rtl/clsr_pkg.sv
// Package for the clock synthesizer ratio calculator.
// Holds field widths, register indexes, reset values and fixed constants.
// No dependencies.
package clsr_pkg;

  localparam int FreqW     = 28;
  localparam int XtalW     = 26;
  localparam int PllMaxW   = 30;
  localparam int ByteW     = 8;
  localparam int RegIdxW   = 3;
  localparam int PaddrW    = 5;
  localparam int PdataW    = 32;
  localparam int FracW     = 20;
  localparam int P1W       = 18;
  localparam int DivKeepW  = 11;
  localparam int CntW      = 5;

  localparam logic [FracW-1:0] FracDenom   = 20'hFFFFF;
  localparam logic [ByteW-1:0] PllResetCmd = 8'hA0;
  localparam logic [P1W-1:0]   P1Offset    = 18'd512;
  localparam logic [CntW-1:0]  LastIdx     = 5'd17;
  localparam logic [CntW-1:0]  MsFirstIdx  = 5'd8;
  localparam logic [CntW-1:0]  ResetIdx    = 5'd16;

  localparam logic [XtalW-1:0]   XtalReset    = 26'd25000000;
  localparam logic [PllMaxW-1:0] PllMaxReset  = 30'd900000000;
  localparam logic [ByteW-1:0]   PllBaseReset = 8'd26;
  localparam logic [ByteW-1:0]   MsBaseReset  = 8'd42;
  localparam logic [ByteW-1:0]   RDivReset    = 8'd0;
  localparam logic [ByteW-1:0]   PllRstReset  = 8'd177;
  localparam logic [ByteW-1:0]   ClkAddrReset = 8'd16;
  localparam logic [ByteW-1:0]   ClkValReset  = 8'd207;

  typedef enum logic [RegIdxW-1:0] {
    RegXtal    = 3'd0,
    RegPllMax  = 3'd1,
    RegPllBase = 3'd2,
    RegMsBase  = 3'd3,
    RegRDiv    = 3'd4,
    RegPllRst  = 3'd5,
    RegClkAddr = 3'd6,
    RegClkVal  = 3'd7
  } reg_idx_t;

endpackage

FILE: rtl/clsr_if.sv
// Handshake channel interfaces for the ratio calculator.
// Depends on clsr_pkg for the field widths.
interface clsr_freq_if;
  logic                           valid;
  logic                           ready;
  logic [clsr_pkg::FreqW-1:0]     frequency;
  modport source (output valid, output frequency, input ready);
  modport sink (input valid, input frequency, output ready);
endinterface

interface clsr_wr_if;
  logic                           valid;
  logic                           ready;
  logic [clsr_pkg::ByteW-1:0]     target_addr;
  logic [clsr_pkg::ByteW-1:0]     reg_data;
  logic                           last;
  modport source (output valid, output target_addr, output reg_data, output last, input ready);
  modport sink (input valid, input target_addr, input reg_data, input last, output ready);
endinterface

FILE: rtl/clock_synth_ratio_calc.sv
// Clock synthesizer ratio calculator, top level. Depends on clsr_pkg, clsr_if, clsr_div.
// The first of the 18 register writes follows the output, multiplier and fraction dividers;
// the pipeline holds up to 83 items ahead of the one being sent. The output stage sends one
// write a cycle while wr.ready is high and takes the next item as its last write goes out.
// Reset (synchronous, active high) clears all valid bits and the write counter and loads
// the configuration registers with their default values; no clearing pass is needed.
module clock_synth_ratio_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clsr_pkg::PaddrW-1:0]   paddr,
  input  logic [clsr_pkg::PdataW-1:0]   pwdata,
  output logic [clsr_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  clsr_freq_if.sink                     req,
  clsr_wr_if.source                     wr
);

  localparam int FreqW   = clsr_pkg::FreqW;
  localparam int XtalW   = clsr_pkg::XtalW;
  localparam int PllW    = clsr_pkg::PllMaxW;
  localparam int ByteW   = clsr_pkg::ByteW;
  localparam int FracW   = clsr_pkg::FracW;
  localparam int P1W     = clsr_pkg::P1W;
  localparam int KeepW   = clsr_pkg::DivKeepW;
  localparam int CntW    = clsr_pkg::CntW;
  localparam int ProdW   = FracW + XtalW;

  // Configuration registers.
  logic [XtalW-1:0] xtal_hz;
  logic [PllW-1:0]  pll_max_freq;
  logic [ByteW-1:0] pll_base_addr;
  logic [ByteW-1:0] ms_base_addr;
  logic [ByteW-1:0] r_div_bits;
  logic [ByteW-1:0] pll_reset_addr;
  logic [ByteW-1:0] clk_ctrl_addr;
  logic [ByteW-1:0] clk_ctrl_value;

  clsr_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = clsr_pkg::reg_idx_t'(paddr[clsr_pkg::PaddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      xtal_hz        <= clsr_pkg::XtalReset;
      pll_max_freq   <= clsr_pkg::PllMaxReset;
      pll_base_addr  <= clsr_pkg::PllBaseReset;
      ms_base_addr   <= clsr_pkg::MsBaseReset;
      r_div_bits     <= clsr_pkg::RDivReset;
      pll_reset_addr <= clsr_pkg::PllRstReset;
      clk_ctrl_addr  <= clsr_pkg::ClkAddrReset;
      clk_ctrl_value <= clsr_pkg::ClkValReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        clsr_pkg::RegXtal:    xtal_hz        <= pwdata[XtalW-1:0];
        clsr_pkg::RegPllMax:  pll_max_freq   <= pwdata[PllW-1:0];
        clsr_pkg::RegPllBase: pll_base_addr  <= pwdata[ByteW-1:0];
        clsr_pkg::RegMsBase:  ms_base_addr   <= pwdata[ByteW-1:0];
        clsr_pkg::RegRDiv:    r_div_bits     <= pwdata[ByteW-1:0];
        clsr_pkg::RegPllRst:  pll_reset_addr <= pwdata[ByteW-1:0];
        clsr_pkg::RegClkAddr: clk_ctrl_addr  <= pwdata[ByteW-1:0];
        clsr_pkg::RegClkVal:  clk_ctrl_value <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      clsr_pkg::RegXtal:    prdata = {{(32-XtalW){1'b0}}, xtal_hz};
      clsr_pkg::RegPllMax:  prdata = {{(32-PllW){1'b0}}, pll_max_freq};
      clsr_pkg::RegPllBase: prdata = {24'd0, pll_base_addr};
      clsr_pkg::RegMsBase:  prdata = {24'd0, ms_base_addr};
      clsr_pkg::RegRDiv:    prdata = {24'd0, r_div_bits};
      clsr_pkg::RegPllRst:  prdata = {24'd0, pll_reset_addr};
      clsr_pkg::RegClkAddr: prdata = {24'd0, clk_ctrl_addr};
      clsr_pkg::RegClkVal:  prdata = {24'd0, clk_ctrl_value};
      default:              prdata = '0;
    endcase
  end

  // Pipeline advance: everything moves unless the last stage is full and
  // the output stage cannot take it.
  logic en;
  logic v_f;
  logic ser_take;
  logic busy;
  logic [CntW-1:0] cnt;
  logic out_xfer;

  assign out_xfer = wr.valid && wr.ready;
  assign ser_take = !busy || (out_xfer && cnt == clsr_pkg::LastIdx);
  assign en       = !v_f || ser_take;
  assign req.ready = en;

  // Output divider: pll_max_freq / frequency.
  logic             v1;
  logic [PllW-1:0]  q1;
  logic [FreqW-1:0] r1;
  logic [FreqW-1:0] f1;
  logic             fz1;

  clsr_div #(.QW(PllW), .VW(FreqW), .SW(1)) u_div_out (
    .clk, .rst, .en,
    .vin      (req.valid),
    .rem_in   ('0),
    .dvd_in   (pll_max_freq),
    .dsr_in   (req.frequency),
    .side_in  (req.frequency == '0),
    .vout     (v1),
    .quo_out  (q1),
    .rem_out  (r1),
    .dsr_out  (f1),
    .side_out (fz1)
  );

  // The remainder of the first division is not needed.
  logic unused_r1;
  assign unused_r1 = ^r1;

  // Multiply stage: the PLL frequency is the even divider times the frequency.
  logic            v_m;
  logic [PllW-1:0] div_c;
  logic [KeepW-1:0] div_m;
  logic [PllW-1:0] pll_m;

  assign div_c = fz1 ? '0 : {q1[PllW-1:1], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (en) begin
      v_m <= v1;
    end
    if (en) begin
      div_m <= div_c[KeepW-1:0];
      pll_m <= PllW'(div_c * {{(PllW-FreqW){1'b0}}, f1});
    end
  end

  // Multiplier: PLL frequency over the crystal.
  logic             v2;
  logic [PllW-1:0]  q2;
  logic [XtalW-1:0] r2;
  logic [XtalW-1:0] x2;
  logic [KeepW-1:0] div_2;

  clsr_div #(.QW(PllW), .VW(XtalW), .SW(KeepW)) u_div_mult (
    .clk, .rst, .en,
    .vin      (v_m),
    .rem_in   ('0),
    .dvd_in   (pll_m),
    .dsr_in   (xtal_hz),
    .side_in  (div_m),
    .vout     (v2),
    .quo_out  (q2),
    .rem_out  (r2),
    .dsr_out  (x2),
    .side_out (div_2)
  );

  // Prepare the fraction: remainder times (2^20 - 1). The quotient is known to
  // stay below 2^20, so the top part of the product is already a partial remainder.
  logic             v_p;
  logic             xz2;
  logic [XtalW-1:0] rem_c;
  logic [ProdW-1:0] prod_c;
  logic [XtalW-1:0] hi_p;
  logic [FracW-1:0] lo_p;
  logic [ByteW-1:0] mult_p;
  logic [KeepW-1:0] div_p;

  assign xz2    = x2 == '0;
  assign rem_c  = xz2 ? '0 : r2;
  assign prod_c = {rem_c, {FracW{1'b0}}} - {{FracW{1'b0}}, rem_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (en) begin
      v_p <= v2;
    end
    if (en) begin
      hi_p   <= prod_c[ProdW-1:FracW];
      lo_p   <= prod_c[FracW-1:0];
      mult_p <= xz2 ? '0 : q2[ByteW-1:0];
      div_p  <= div_2;
    end
  end

  // Fraction numerator: remainder * (2^20 - 1) over the crystal.
  logic                    v3;
  logic [FracW-1:0]        q3;
  logic [XtalW-1:0]        r3;
  logic [XtalW-1:0]        x3;
  logic [ByteW+KeepW-1:0]  side3;

  clsr_div #(.QW(FracW), .VW(XtalW), .SW(ByteW + KeepW)) u_div_frac (
    .clk, .rst, .en,
    .vin      (v_p),
    .rem_in   (hi_p),
    .dvd_in   (lo_p),
    .dsr_in   (xtal_hz),
    .side_in  ({mult_p, div_p}),
    .vout     (v3),
    .quo_out  (q3),
    .rem_out  (r3),
    .dsr_out  (x3),
    .side_out (side3)
  );

  logic unused_r3;
  assign unused_r3 = ^r3;

  // Final stage: split 128*num by 2^20 - 1 with one correction step, then
  // form the P1 and P2 values.
  logic [FracW-1:0]  num_c;
  logic [FracW+6:0]  x_c;
  logic [6:0]        q0_c;
  logic [FracW:0]    r_c;
  logic              ge_c;
  logic [6:0]        frac_c;
  logic [FracW:0]    rsub_c;
  logic [ByteW-1:0]  mult_c;
  logic [KeepW-1:0]  div_f;
  logic [P1W-1:0]    p1_f;
  logic [FracW-1:0]  p2_f;
  logic [P1W-1:0]    ms_f;

  always_comb begin
    num_c  = (x3 == '0) ? '0 : q3;
    mult_c = side3[ByteW+KeepW-1:KeepW];
    div_f  = side3[KeepW-1:0];
    x_c    = {num_c, 7'd0};
    q0_c   = x_c[FracW+6:FracW];
    r_c    = {1'b0, x_c[FracW-1:0]} + {{(FracW-6){1'b0}}, q0_c};
    ge_c   = r_c >= {1'b0, clsr_pkg::FracDenom};
    rsub_c = r_c - {1'b0, clsr_pkg::FracDenom};
    frac_c = q0_c + {6'd0, ge_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else if (en) begin
      v_f <= v3;
    end
    if (en) begin
      p1_f <= {3'd0, mult_c, 7'd0} + {11'd0, frac_c} - clsr_pkg::P1Offset;
      p2_f <= ge_c ? rsub_c[FracW-1:0] : r_c[FracW-1:0];
      ms_f <= {div_f, 7'd0} - clsr_pkg::P1Offset;
    end
  end

  // Output stage: holds one item's values and sends its 18 writes in turn.
  logic [P1W-1:0]   p1_s;
  logic [FracW-1:0] p2_s;
  logic [P1W-1:0]   ms_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ser_take) begin
      busy <= v_f;
      cnt  <= '0;
    end else if (out_xfer) begin
      cnt <= cnt + 1'b1;
    end
    if (ser_take && v_f) begin
      p1_s <= p1_f;
      p2_s <= p2_f;
      ms_s <= ms_f;
    end
  end

  logic [ByteW-1:0] data_c;
  logic [ByteW-1:0] addr_c;

  always_comb begin
    data_c = '0;
    addr_c = pll_base_addr + {5'd0, cnt[2:0]};
    if (cnt < clsr_pkg::MsFirstIdx) begin
      case (cnt[2:0])
        3'd0:    data_c = 8'hFF;
        3'd1:    data_c = 8'hFF;
        3'd2:    data_c = {6'd0, p1_s[17:16]};
        3'd3:    data_c = p1_s[15:8];
        3'd4:    data_c = p1_s[7:0];
        3'd5:    data_c = {4'hF, p2_s[19:16]};
        3'd6:    data_c = p2_s[15:8];
        3'd7:    data_c = p2_s[7:0];
        default: data_c = '0;
      endcase
    end else if (cnt < clsr_pkg::ResetIdx) begin
      addr_c = ms_base_addr + {5'd0, cnt[2:0]};
      case (cnt[2:0])
        3'd1:    data_c = 8'h01;
        3'd2:    data_c = {6'd0, ms_s[17:16]} | r_div_bits;
        3'd3:    data_c = ms_s[15:8];
        3'd4:    data_c = ms_s[7:0];
        default: data_c = '0;
      endcase
    end else if (cnt == clsr_pkg::ResetIdx) begin
      addr_c = pll_reset_addr;
      data_c = clsr_pkg::PllResetCmd;
    end else begin
      addr_c = clk_ctrl_addr;
      data_c = clk_ctrl_value;
    end
  end

  assign wr.valid       = busy;
  assign wr.target_addr = addr_c;
  assign wr.reg_data    = data_c;
  assign wr.last        = cnt == clsr_pkg::LastIdx;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= clsr_pkg::LastIdx)
    else $error("write counter out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v_f && busy))
    else $error("input stalled without a full final stage");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !wr.last) |=> (busy && cnt == $past(cnt) + 1'b1))
    else $error("write sequence did not advance by one");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && wr.last) |=> (!busy || cnt == '0))
    else $error("new item did not start at the first write");
`endif

endmodule

FILE: rtl/clsr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries the divisor and a side payload with each item; no package use.
module clsr_div #(
  parameter int QW = 30,
  parameter int VW = 28,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [VW-1:0] rem_in,
  input  logic [QW-1:0] dvd_in,
  input  logic [VW-1:0] dsr_in,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [QW-1:0] quo_out,
  output logic [VW-1:0] rem_out,
  output logic [VW-1:0] dsr_out,
  output logic [SW-1:0] side_out
);

  logic          vld  [0:QW];
  logic [VW-1:0] rem  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [QW-1:0] dvd  [0:QW];
  logic [VW-1:0] dsr  [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = vin;
  assign rem[0]  = rem_in;
  assign quo[0]  = '0;
  assign dvd[0]  = dvd_in;
  assign dsr[0]  = dsr_in;
  assign side[0] = side_in;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[s], dvd[s][QW-1]};
      diff  = trial - {1'b0, dsr[s]};
      ge    = trial >= {1'b0, dsr[s]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
        quo[s+1]  <= {quo[s][QW-2:0], ge};
        dvd[s+1]  <= {dvd[s][QW-2:0], 1'b0};
        dsr[s+1]  <= dsr[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign vout     = vld[QW];
  assign quo_out  = quo[QW];
  assign rem_out  = rem[QW];
  assign dsr_out  = dsr[QW];
  assign side_out = side[QW];

endmodule
